// File: hw/rtl/login_failure_lockout_table_defines.svh
// ----------------------------------------------------------------------------
// Login failure lockout table - assertion macros
// Shared property wrappers for the lockout table RTL.
// ----------------------------------------------------------------------------
`ifndef LOGIN_FAILURE_LOCKOUT_TABLE_DEFINES_SVH
`define LOGIN_FAILURE_LOCKOUT_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LFLT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define LFLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lflt_pkg.sv
// ----------------------------------------------------------------------------
// Lockout table package
// Types, request codes and register constants shared by the lockout table.
// ----------------------------------------------------------------------------
package lflt_pkg;

    // default table depth
    localparam int LFLT_ENTRIES = 32;

    // request modes
    localparam logic [1:0] MODE_QUERY   = 2'd0;
    localparam logic [1:0] MODE_FAIL    = 2'd1;
    localparam logic [1:0] MODE_SUCCESS = 2'd2;

    // register select (paddr bit 2)
    localparam logic REG_FAIL_LIMIT   = 1'b0;
    localparam logic REG_LOCK_SECONDS = 1'b1;

    // register reset values
    localparam logic [7:0]  FAIL_LIMIT_RST   = 8'd5;
    localparam logic [15:0] LOCK_SECONDS_RST = 16'd30;

    localparam logic [7:0]  COUNT_MAX = 8'hFF;
    localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;
    localparam logic [15:0] LEFT_MAX  = 16'hFFFF;

    // input request
    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [31:0] now_seconds;
    } t_req;

    // result
    typedef struct packed {
        logic        locked;
        logic [15:0] remain_secs;
    } t_rsp;

    // one table entry as stored in memory
    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [7:0]  fail_count;
        logic [31:0] lock_until;
    } t_entry;

    // scan outcome flags
    typedef struct packed {
        logic hit;
        logic free_found;
        logic old_found;
    } t_scan_flags;

endpackage

// File: hw/rtl/login_failure_lockout_table.sv
// ----------------------------------------------------------------------------
// Login failure lockout table
// Per-address failure counting and lockout with a scanned entry memory.
//
//   Channel   Direction  Handshake                     Payload
//   in        input      i_in_valid / o_in_stall       i_in_req  (t_req)
//   out       output     o_out_valid / i_out_stall     o_out_rsp (t_rsp)
//   config    input      psel/penable/pwrite, pready   paddr, pwdata, prdata
//
// Each request sweeps the entry memory through its single read port; a
// failure or success then updates the table, and the result is handed to
// the output register.
// Reset marks every entry unused at once; no clearing pass is needed.
// The next request is accepted while a result waits in the output register;
// a stalled output holds the block only once the next result is ready.
// ----------------------------------------------------------------------------
`include "login_failure_lockout_table_defines.svh"

module login_failure_lockout_table
    import lflt_pkg::*;
#(
    parameter int ENTRIES = LFLT_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_req        i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_rsp        o_out_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_DONE
    } t_state;

    t_state           r_state;
    t_req             r_req;
    t_rsp             r_res;
    t_rsp             r_out_rsp;
    logic             r_out_valid;
    logic             r_start;
    logic [ENTRIES-1:0] r_used;
    logic [7:0]       r_fail_limit;
    logic [15:0]      r_lock_seconds;

    logic             in_accept;
    logic             cfg_write;
    logic             out_load_ok;

    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    t_entry           mem_rd_data;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    t_entry           mem_wr_data;

    logic             scan_done;
    t_scan_flags      scan_flags;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] old_idx;
    t_entry           hit_entry;

    t_rsp             res_calc;
    logic [31:0]      left_full;
    logic [7:0]       base_count;
    logic [31:0]      base_lock;
    logic [7:0]       count_clr;
    logic [7:0]       count_inc;
    logic [32:0]      lock_sum;
    logic [31:0]      lock_new;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign cfg_write   = psel && penable && pwrite;
    assign out_load_ok = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_limit   <= FAIL_LIMIT_RST;
            r_lock_seconds <= LOCK_SECONDS_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_FAIL_LIMIT:   r_fail_limit   <= pwdata[7:0];
                REG_LOCK_SECONDS: r_lock_seconds <= pwdata[15:0];
                default:          r_fail_limit   <= r_fail_limit;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[2])
            REG_FAIL_LIMIT:   prdata = {24'd0, r_fail_limit};
            REG_LOCK_SECONDS: prdata = {16'd0, r_lock_seconds};
            default:          prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // entry memory and scanner
    lflt_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    lflt_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_start),
        .i_key_high  (r_req.key_high),
        .i_key_low   (r_req.key_low),
        .i_used      (r_used),
        .i_rd_data   (mem_rd_data),
        .o_rd_en     (mem_rd_en),
        .o_rd_addr   (mem_rd_addr),
        .o_done      (scan_done),
        .o_flags     (scan_flags),
        .o_hit_idx   (hit_idx),
        .o_free_idx  (free_idx),
        .o_old_idx   (old_idx),
        .o_hit_entry (hit_entry)
    );

    // update of the chosen entry and the query answer
    always_comb begin
        // query
        left_full = hit_entry.lock_until - r_req.now_seconds;
        res_calc  = '0;
        if (r_req.mode == MODE_QUERY && scan_flags.hit &&
            hit_entry.lock_until > r_req.now_seconds) begin
            res_calc.locked      = 1'b1;
            res_calc.remain_secs = (|left_full[31:16]) ? LEFT_MAX : left_full[15:0];
        end

        // failure: matched entry keeps its state, a claimed one starts clean
        base_count = scan_flags.hit ? hit_entry.fail_count : 8'd0;
        base_lock  = scan_flags.hit ? hit_entry.lock_until : 32'd0;
        count_clr  = (base_lock != 32'd0 && base_lock <= r_req.now_seconds) ? 8'd0 : base_count;
        count_inc  = (count_clr == COUNT_MAX) ? COUNT_MAX : count_clr + 8'd1;
        lock_sum   = {1'b0, r_req.now_seconds} + {17'd0, r_lock_seconds};
        lock_new   = lock_sum[32] ? TIME_MAX : lock_sum[31:0];

        mem_wr_data.key_high   = r_req.key_high;
        mem_wr_data.key_low    = r_req.key_low;
        mem_wr_data.fail_count = count_inc;
        mem_wr_data.lock_until = base_lock;
        if (count_inc >= r_fail_limit) begin
            mem_wr_data.fail_count = 8'd0;
            mem_wr_data.lock_until = lock_new;
        end

        if (scan_flags.hit) begin
            mem_wr_addr = hit_idx;
        end else if (scan_flags.free_found) begin
            mem_wr_addr = free_idx;
        end else begin
            mem_wr_addr = old_idx;
        end
    end

    assign mem_wr_en = (r_state == S_SCAN) && scan_done && (r_req.mode == MODE_FAIL);

    // sequencer, used bits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_used      <= '0;
        end else begin
            r_start <= in_accept;
            // output valid: load a finished result, drop an accepted one
            if (r_state == S_DONE && out_load_ok) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_req   <= i_in_req;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_res <= res_calc;
                        if (mem_wr_en) begin
                            r_used[mem_wr_addr] <= 1'b1;
                        end
                        if (r_req.mode == MODE_SUCCESS && scan_flags.hit) begin
                            r_used[hit_idx] <= 1'b0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load_ok) begin
                        r_out_rsp <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // checks
    `LFLT_ASSERT_SAME(a_done_in_scan, i_clk, i_rst_n, scan_done, r_state == S_SCAN,
        "scan finished outside scan state")
    `LFLT_ASSERT_SAME(a_write_on_fail, i_clk, i_rst_n, mem_wr_en,
        scan_done && r_req.mode == MODE_FAIL, "entry write without a failure request")
    `LFLT_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, r_state == S_DONE && !r_out_valid,
        r_out_valid, "finished result not presented")
    `LFLT_ASSERT_SAME(a_locked_left, i_clk, i_rst_n, r_out_valid,
        r_out_rsp.locked == (r_out_rsp.remain_secs != 16'd0),
        "locked flag disagrees with seconds left")

endmodule

// File: hw/rtl/lflt_mem.sv
// ----------------------------------------------------------------------------
// Lockout table entry memory
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module lflt_mem
    import lflt_pkg::*;
#(
    parameter int ENTRIES = LFLT_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  t_entry                     i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output t_entry                     o_rd_data
);

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/lflt_scan.sv
// ----------------------------------------------------------------------------
// Lockout table scanner
// Walks every entry once per request: finds the matching key, the first
// free slot and the used entry with the smallest lock time.
// ----------------------------------------------------------------------------
module lflt_scan
    import lflt_pkg::*;
#(
    parameter int ENTRIES = LFLT_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [63:0]                i_key_high,
    input  logic [63:0]                i_key_low,
    input  logic [ENTRIES-1:0]         i_used,
    input  t_entry                     i_rd_data,
    output logic                       o_rd_en,
    output logic [$clog2(ENTRIES)-1:0] o_rd_addr,
    output logic                       o_done,
    output t_scan_flags                o_flags,
    output logic [$clog2(ENTRIES)-1:0] o_hit_idx,
    output logic [$clog2(ENTRIES)-1:0] o_free_idx,
    output logic [$clog2(ENTRIES)-1:0] o_old_idx,
    output t_entry                     o_hit_entry
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic             r_issue;
    logic             r_chk;
    logic             r_done;
    logic [IDX_W-1:0] r_addr;
    logic [IDX_W-1:0] r_chk_idx;
    logic             r_chk_used;
    logic             r_chk_last;
    t_scan_flags      r_flags;
    logic [IDX_W-1:0] r_hit_idx;
    logic [IDX_W-1:0] r_free_idx;
    logic [IDX_W-1:0] r_old_idx;
    logic [31:0]      r_old_lock;
    t_entry           r_hit_entry;
    logic             key_eq;

    assign key_eq = (i_rd_data.key_high == i_key_high) && (i_rd_data.key_low == i_key_low);

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_chk   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_chk  <= r_issue;
            r_done <= r_chk && r_chk_last;
            if (i_start) begin
                r_issue <= 1'b1;
            end else if (r_issue && r_addr == LAST_IDX) begin
                r_issue <= 1'b0;
            end
        end
    end

    // address walk and compare pipeline
    always_ff @(posedge i_clk) begin
        r_chk_idx  <= r_addr;
        r_chk_last <= (r_addr == LAST_IDX);
        r_chk_used <= i_used[r_addr];
        if (i_start) begin
            r_addr  <= '0;
            r_flags <= '0;
        end else begin
            if (r_issue) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            if (r_chk) begin
                if (r_chk_used) begin
                    // matching key
                    if (key_eq && !r_flags.hit) begin
                        r_flags.hit <= 1'b1;
                        r_hit_idx   <= r_chk_idx;
                        r_hit_entry <= i_rd_data;
                    end
                    // smallest lock time, lowest index on ties
                    if (!r_flags.old_found || i_rd_data.lock_until < r_old_lock) begin
                        r_flags.old_found <= 1'b1;
                        r_old_idx         <= r_chk_idx;
                        r_old_lock        <= i_rd_data.lock_until;
                    end
                end else if (!r_flags.free_found) begin
                    r_flags.free_found <= 1'b1;
                    r_free_idx         <= r_chk_idx;
                end
            end
        end
    end

    assign o_rd_en     = r_issue;
    assign o_rd_addr   = r_addr;
    assign o_done      = r_done;
    assign o_flags     = r_flags;
    assign o_hit_idx   = r_hit_idx;
    assign o_free_idx  = r_free_idx;
    assign o_old_idx   = r_old_idx;
    assign o_hit_entry = r_hit_entry;

endmodule
